/* sv/assert_macros.svh */
// Assertion helpers shared by the calendar converter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

/* sv/usc_pkg.sv */
package usc_pkg;

    // Which constant division the shared multiplier is working on
    typedef enum logic [1:0] {
        DIV_SEC  = 2'd0,
        DIV_MIN  = 2'd1,
        DIV_HOUR = 2'd2,
        DIV_WDAY = 2'd3
    } div_stage_t;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_MUL   = 3'd2,
        OP_SPLIT = 3'd3,
        OP_YEAR  = 3'd4,
        OP_MONTH = 3'd5,
        OP_PUB   = 3'd6
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        div_stage_t stage;
    } usc_cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } usc_stat_t;

    // Reciprocals: floor(n/60) = ((n>>2) * RECIP_15) >> 34, n < 2^32
    //              floor(n/24) = ((n>>3) * RECIP_3)  >> 20, n < 2^21
    //              floor(n/7)  = (n * RECIP_7)       >> 20, n < 2^17
    localparam logic [30:0] RECIP_15 = 31'd1145324613;
    localparam logic [30:0] RECIP_3  = 31'd349526;
    localparam logic [30:0] RECIP_7  = 31'd149797;

    localparam logic [31:0] SECS_PER_MIN  = 32'd60;
    localparam logic [31:0] MINS_PER_HOUR = 32'd60;
    localparam logic [31:0] HOURS_PER_DAY = 32'd24;
    localparam logic [31:0] DAYS_PER_WEEK = 32'd7;
    // 1970-01-01 was a Thursday
    localparam logic [31:0] WDAY_OFFSET   = 32'd3;

    // Year index counts from 1970; inputs never reach past 2106
    localparam logic [7:0] YIDX_2000 = 8'd30;
    localparam logic [7:0] YIDX_2100 = 8'd130;
    localparam logic [7:0] YIDX_MAX  = 8'd136;
    localparam logic [3:0] MON_DEC   = 4'd11;

    // 1970 + yidx is a leap year: divisible by four, but not 2100
    function automatic logic is_leap(input logic [7:0] yidx);
        return (yidx[1:0] == 2'd2) && (yidx != YIDX_2100);
    endfunction

    // Month index counts from 0 for January
    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd1:                    len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* sv/usc_ctrl.sv */
`include "assert_macros.svh"

module usc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  usc_pkg::usc_stat_t  stat,
    output usc_pkg::usc_cmd_t   cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_SPLIT = 6'b000100,
        S_YEAR  = 6'b001000,
        S_MONTH = 6'b010000,
        S_PUB   = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    usc_pkg::div_stage_t   stage_reg, stage_next;
    logic                  out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        stage_next     = stage_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = usc_pkg::OP_NONE;
        cmd.stage      = stage_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = usc_pkg::OP_LOAD;
                    stage_next = usc_pkg::DIV_SEC;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.op     = usc_pkg::OP_MUL;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.op = usc_pkg::OP_SPLIT;
                if (stage_reg == usc_pkg::DIV_WDAY)
                begin
                    state_next = S_YEAR;
                end
                else
                begin
                    stage_next = usc_pkg::div_stage_t'(stage_reg + 2'd1);
                    state_next = S_MUL;
                end
            end
            S_YEAR:
            begin
                cmd.op = usc_pkg::OP_YEAR;
                if (stat.year_done)
                begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                cmd.op = usc_pkg::OP_MONTH;
                if (stat.month_done)
                begin
                    state_next = S_PUB;
                end
            end
            S_PUB:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = usc_pkg::OP_PUB;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stage_reg     <= usc_pkg::DIV_SEC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_CLK(a_pub_free, (cmd.op == usc_pkg::OP_PUB) |-> (!out_valid_reg || out_ready),
        "publish would overwrite an untaken word")
    `ASSERT_CLK(a_accept_start, (in_valid && in_ready) |=>
        (state_reg == S_MUL && stage_reg == usc_pkg::DIV_SEC),
        "accepted word did not start the seconds division")
    `ASSERT_CLK(a_year_to_month, (state_reg == S_YEAR && stat.year_done) |=>
        (state_reg == S_MONTH), "year search did not hand over to month search")

endmodule

/* sv/usc_dp.sv */
`include "assert_macros.svh"

module usc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  usc_pkg::usc_cmd_t   cmd,
    output usc_pkg::usc_stat_t  stat,
    input  logic [31:0]         unix_seconds,
    output logic [5:0]          second,
    output logic [5:0]          minute,
    output logic [4:0]          hour,
    output logic [2:0]          weekday,
    output logic [4:0]          day_of_month,
    output logic [3:0]          month_number,
    output logic [7:0]          year_since_2000
);

    logic [31:0] num_reg;
    logic [60:0] prod_reg;
    logic [5:0]  sec_reg, min_reg;
    logic [4:0]  hour_reg;
    logic [2:0]  wd_reg;
    logic [15:0] days_reg;
    logic [7:0]  yidx_reg;
    logic [3:0]  mon_reg;

    logic [5:0]  second_reg, minute_reg;
    logic [4:0]  hour_out_reg, dom_reg;
    logic [2:0]  weekday_reg;
    logic [3:0]  month_reg;
    logic [7:0]  year_reg;

    logic [29:0] mul_a;
    logic [30:0] mul_b;
    logic [31:0] quot, divisor, rem;
    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;

    // operand select for the shared reciprocal multiplier
    always_comb
    begin
        case (cmd.stage)
            usc_pkg::DIV_SEC, usc_pkg::DIV_MIN:
            begin
                mul_a   = num_reg[31:2];
                mul_b   = usc_pkg::RECIP_15;
                quot    = 32'(prod_reg[60:34]);
                divisor = (cmd.stage == usc_pkg::DIV_SEC) ? usc_pkg::SECS_PER_MIN
                                                          : usc_pkg::MINS_PER_HOUR;
            end
            usc_pkg::DIV_HOUR:
            begin
                mul_a   = 30'(num_reg[31:3]);
                mul_b   = usc_pkg::RECIP_3;
                quot    = prod_reg[51:20];
                divisor = usc_pkg::HOURS_PER_DAY;
            end
            default:
            begin
                mul_a   = num_reg[29:0];
                mul_b   = usc_pkg::RECIP_7;
                quot    = prod_reg[51:20];
                divisor = usc_pkg::DAYS_PER_WEEK;
            end
        endcase
        rem = num_reg - quot * divisor;
    end

    assign leap     = usc_pkg::is_leap(yidx_reg);
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mon_len  = usc_pkg::month_days(mon_reg, leap);

    assign stat.year_done  = (days_reg < 16'(year_len));
    assign stat.month_done = (mon_reg == usc_pkg::MON_DEC) || (days_reg < 16'(mon_len));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yidx_reg <= '0;
            mon_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                usc_pkg::OP_LOAD:
                begin
                    yidx_reg <= '0;
                    mon_reg  <= '0;
                end
                usc_pkg::OP_YEAR:
                begin
                    if (!stat.year_done)
                    begin
                        yidx_reg <= yidx_reg + 8'd1;
                    end
                end
                usc_pkg::OP_MONTH:
                begin
                    if (!stat.month_done)
                    begin
                        mon_reg <= mon_reg + 4'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            usc_pkg::OP_LOAD:
            begin
                num_reg <= unix_seconds;
            end
            usc_pkg::OP_MUL:
            begin
                prod_reg <= 61'(mul_a * mul_b);
            end
            usc_pkg::OP_SPLIT:
            begin
                case (cmd.stage)
                    usc_pkg::DIV_SEC:
                    begin
                        sec_reg <= rem[5:0];
                        num_reg <= quot;
                    end
                    usc_pkg::DIV_MIN:
                    begin
                        min_reg <= rem[5:0];
                        num_reg <= quot;
                    end
                    usc_pkg::DIV_HOUR:
                    begin
                        hour_reg <= rem[4:0];
                        days_reg <= quot[15:0];
                        num_reg  <= quot + usc_pkg::WDAY_OFFSET;
                    end
                    default:
                    begin
                        wd_reg <= rem[2:0] + 3'd1;
                    end
                endcase
            end
            usc_pkg::OP_YEAR:
            begin
                if (!stat.year_done)
                begin
                    days_reg <= days_reg - 16'(year_len);
                end
            end
            usc_pkg::OP_MONTH:
            begin
                if (!stat.month_done)
                begin
                    days_reg <= days_reg - 16'(mon_len);
                end
            end
            usc_pkg::OP_PUB:
            begin
                second_reg   <= sec_reg;
                minute_reg   <= min_reg;
                hour_out_reg <= hour_reg;
                weekday_reg  <= wd_reg;
                dom_reg      <= days_reg[4:0] + 5'd1;
                month_reg    <= mon_reg + 4'd1;
                year_reg     <= yidx_reg - usc_pkg::YIDX_2000;
            end
            default:
            begin
            end
        endcase
    end

    assign second          = second_reg;
    assign minute          = minute_reg;
    assign hour            = hour_out_reg;
    assign weekday         = weekday_reg;
    assign day_of_month    = dom_reg;
    assign month_number    = month_reg;
    assign year_since_2000 = year_reg;

    `ASSERT_CLK(a_month_days, (cmd.op == usc_pkg::OP_MONTH) |-> (days_reg < 16'd366),
        "month search entered with a full year of days left")
    `ASSERT_NEVER(a_year_range, (cmd.op == usc_pkg::OP_YEAR) && (yidx_reg > usc_pkg::YIDX_MAX),
        "year search ran past 2106")

endmodule

/* sv/unix_seconds_to_calendar.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    unix_seconds[31:0]
// out       output     out_valid / out_ready  second, minute, hour, weekday,
//                                             day_of_month, month_number,
//                                             year_since_2000
//
// An accepted word is split by the three divisions and the weekday modulo, which
// share one reciprocal multiplier; then the year and month searches walk the days,
// one subtraction a cycle, and the publish step loads the output register. Take a new
// word once the previous one sits in the output register; a stalled output holds the
// next result back in its publish step. Reset clears the controller and drops any word.
module unix_seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] unix_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [2:0]  weekday,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_number,
    output logic [7:0]  year_since_2000
);

    // command from the sequencer, search status back from the datapath
    usc_pkg::usc_cmd_t  cmd;
    usc_pkg::usc_stat_t stat;

    // Sequence: load, then multiply/split for seconds, minutes, hours and
    // weekday, then walk years, then months, then publish.
    usc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic, search counters and the output register.
    usc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .unix_seconds    (unix_seconds),
        .second          (second),
        .minute          (minute),
        .hour            (hour),
        .weekday         (weekday),
        .day_of_month    (day_of_month),
        .month_number    (month_number),
        .year_since_2000 (year_since_2000)
    );

endmodule
